// ===== sv/sba_pkg.sv =====
// Package for the stack blur block: shared types and constants.
// No dependencies.
`default_nettype none
package sba_pkg;
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef struct packed {
    logic       func;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } cmd_t;
endpackage
`default_nettype wire

// ===== sv/sba_queue.sv =====
// Two-entry queue between the command front end and the blur engine.
// Depends on sba_pkg.
`default_nettype none
module sba_queue import sba_pkg::*; (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       flush,
  input  wire       push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire       pop,
  output logic      empty,
  output cmd_t      pop_data
);
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
    if (!rst_n || flush) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== sv/sba_engine.sv =====
// Blur engine: frame memories, load/read handling and the two blur passes.
// Depends on sba_pkg.
`default_nettype none
module sba_engine import sba_pkg::*; #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_RADIUS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         flush,
  input  wire  [5:0]  radius,
  input  wire  [7:0]  width_cfg,
  input  wire  [7:0]  height_cfg,
  input  wire         cmd_valid,
  input  wire  cmd_t  cmd,
  output logic        cmd_pop,
  output logic        res_valid,
  input  wire         res_ready,
  output logic [33:0] res_data
);
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(CELLS + 1);
  localparam int IW = $clog2(CELLS);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_RADIUS + 2);
  localparam int LW = (WW > HW) ? WW : HW;
  localparam int SW = 8 + 2 * RW + 2;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_RDW, S_TAP, S_TAPW, S_DIV, S_OUT} st_t;

  logic [31:0] src_mem [CELLS];
  logic [31:0] row_mem [CELLS];

  st_t         st_r;
  logic [AW-1:0] load_r, rdi_r;
  logic        done_r, pass_r;
  logic [LW-1:0] line_r, pos_r, nlines_r, nlen_r;
  logic signed [RW+1:0] tap_r;
  logic [RW-1:0] r_r;
  logic [SW-1:0] sum_r [4];
  logic [31:0] rdata_r;
  logic [SW-1:0] quo_r [4];
  logic [SW-1:0] rem_r [4];
  logic [4:0]  dstep_r;
  logic [2*RW-1:0] div_r;
  logic [31:0] px_r;

  // effective sizes
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [RW-1:0] r_eff;
  logic [AW-1:0] cells;
  always_comb begin
    if (width_cfg == 8'd0) w_eff = WW'(1);
    else if (32'(width_cfg) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_cfg);
    if (height_cfg == 8'd0) h_eff = HW'(1);
    else if (32'(height_cfg) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(height_cfg);
    if (32'(radius) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
    else r_eff = RW'(radius);
  end
  assign cells = AW'(w_eff) * AW'(h_eff);

  // clamped tap address
  logic signed [LW+RW+2:0] q;
  logic [LW-1:0] qc;
  logic [AW-1:0] taddr;
  logic [RW:0]   wgt;
  always_comb begin
    q = $signed({1'b0, pos_r}) + tap_r;
    if (q < 0) qc = '0;
    else if (q > $signed({1'b0, nlen_r}) - 1) qc = nlen_r - 1'b1;
    else qc = LW'(q);
    if (!pass_r) taddr = AW'(line_r) * AW'(w_eff) + AW'(qc);
    else         taddr = AW'(qc) * AW'(w_eff) + AW'(line_r);
    wgt = (RW+1)'(r_r) + 1'b1 - (RW+1)'(tap_r < 0 ? -tap_r : tap_r);
  end
  logic [AW-1:0] oaddr;
  assign oaddr = !pass_r ? AW'(line_r) * AW'(w_eff) + AW'(pos_r)
                         : AW'(pos_r) * AW'(w_eff) + AW'(line_r);

  // restoring division, one quotient bit per cycle for all four channels
  logic [SW:0] trial [4];
  always_comb
    for (int k = 0; k < 4; k++)
      trial[k] = {rem_r[k], quo_r[k][SW-1]} - {{(SW+1-2*RW){1'b0}}, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      st_r <= S_IDLE; load_r <= '0; rdi_r <= '0; done_r <= 1'b0;
      res_valid <= 1'b0; cmd_pop <= 1'b0;
    end else begin
      cmd_pop <= 1'b0;
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (cmd_valid && !cmd_pop && !(res_valid && !res_ready)) begin
          if (cmd.func == FUNC_LOAD) begin
            cmd_pop <= 1'b1;
            src_mem[load_r[IW-1:0]] <= {cmd.alpha, cmd.red, cmd.green, cmd.blue};
            if (load_r == '0) begin done_r <= 1'b0; rdi_r <= '0; end
            if (load_r + 1'b1 >= cells) begin
              load_r <= '0; rdi_r <= '0;
              r_r <= r_eff; div_r <= (2*RW)'((r_eff + 1) * (r_eff + 1));
              pass_r <= 1'b0; line_r <= '0; pos_r <= '0;
              nlines_r <= LW'(h_eff); nlen_r <= LW'(w_eff);
              tap_r <= -$signed((RW+2)'(r_eff));
              for (int k = 0; k < 4; k++) sum_r[k] <= '0;
              st_r <= S_TAP;
            end else load_r <= load_r + 1'b1;
          end else if (!done_r) begin
            cmd_pop <= 1'b1; res_valid <= 1'b1; res_data <= '0;
          end else begin
            cmd_pop <= 1'b1;
            rdata_r <= src_mem[rdi_r[IW-1:0]];
            st_r <= S_RD;
          end
        end
        S_RD: begin
          res_valid <= 1'b1;
          res_data <= {rdi_r == cells - 1'b1, rdata_r[31:24], rdata_r[7:0],
                       rdata_r[15:8], rdata_r[23:16], 1'b1};
          rdi_r <= (rdi_r == cells - 1'b1) ? '0 : rdi_r + 1'b1;
          st_r <= S_IDLE;
        end
        S_TAP: begin
          rdata_r <= !pass_r ? src_mem[taddr[IW-1:0]] : row_mem[taddr[IW-1:0]];
          px_r <= 32'(wgt);
          st_r <= S_TAPW;
        end
        S_TAPW: begin
          for (int k = 0; k < 4; k++)
            sum_r[k] <= sum_r[k] + SW'(rdata_r[8*k +: 8]) * SW'(px_r[RW:0]);
          if (tap_r == $signed((RW+2)'(r_r))) begin
            for (int k = 0; k < 4; k++) begin quo_r[k] <= '0; rem_r[k] <= '0; end
            dstep_r <= '0; st_r <= S_DIV;
          end else begin
            tap_r <= tap_r + 1'b1; st_r <= S_TAP;
          end
        end
        S_DIV: begin
          if (dstep_r == 5'd0) for (int k = 0; k < 4; k++) quo_r[k] <= sum_r[k];
          else
            for (int k = 0; k < 4; k++)
              if (!trial[k][SW]) begin
                rem_r[k] <= trial[k][SW-1:0];
                quo_r[k] <= {quo_r[k][SW-2:0], 1'b1};
              end else begin
                rem_r[k] <= {rem_r[k][SW-2:0], quo_r[k][SW-1]};
                quo_r[k] <= {quo_r[k][SW-2:0], 1'b0};
              end
          if (dstep_r == 5'(SW)) st_r <= S_OUT;
          dstep_r <= dstep_r + 1'b1;
        end
        default: begin // S_OUT
          if (!pass_r) row_mem[oaddr[IW-1:0]] <= {quo_r[3][7:0], quo_r[2][7:0],
                                                  quo_r[1][7:0], quo_r[0][7:0]};
          else         src_mem[oaddr[IW-1:0]] <= {quo_r[3][7:0], quo_r[2][7:0],
                                                  quo_r[1][7:0], quo_r[0][7:0]};
          for (int k = 0; k < 4; k++) sum_r[k] <= '0;
          tap_r <= -$signed((RW+2)'(r_r));
          st_r <= S_TAP;
          if (pos_r == nlen_r - 1'b1) begin
            pos_r <= '0;
            if (line_r == nlines_r - 1'b1) begin
              line_r <= '0;
              if (!pass_r) begin
                pass_r <= 1'b1; nlines_r <= LW'(w_eff); nlen_r <= LW'(h_eff);
              end else begin
                done_r <= 1'b1; st_r <= S_IDLE;
              end
            end else line_r <= line_r + 1'b1;
          end else pos_r <= pos_r + 1'b1;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/stack_blur_argb.sv =====
// Top level of the ARGB stack blur: config registers, command queue, engine.
// Depends on sba_pkg, sba_queue, sba_engine.
//
// channel | dir | handshake            | payload
// in      | in  | in_tvalid/in_tready  | tuser=func, tdata=R,G,B,A
// out     | out | out_tvalid/out_tready| tuser=ready_res, tdata=R,G,B,A, tlast
// cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A load or a read holds the engine through its decision and then its queue pop.
// The last load of a frame starts both passes: per pixel and pass, a memory read and
// an accumulate step for each of the 2R+1 taps, bit-serial division of SW bits
// (SW=22 at default sizes) and a write-back step. Reset is synchronous; a config
// write abandons the frame. A stalled output holds the engine, the queue absorbs input.
`default_nettype none
module stack_blur_argb import sba_pkg::*; #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int MAX_RADIUS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // red_in, green_in, blue_in, alpha_in
  input  wire         in_tuser,   // func
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // red_out, green_out, blue_out, alpha_out
  output logic        out_tuser,  // ready_res
  output logic        out_tlast,  // last_pixel
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_data
);
  logic [5:0] radius_r;
  logic [7:0] width_r, height_r;
  logic       flush;
  logic       full, empty, pop;
  cmd_t       pushd, popd;
  logic [33:0] res;

  assign cfg_ready = 1'b1;
  assign flush = cfg_valid && (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH ||
                               cfg_index == REG_HEIGHT);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0; width_r <= 8'd128; height_r <= 8'd128;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RADIUS: radius_r <= cfg_data[5:0];
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = !full;
  assign pushd = '{func: in_tuser, red: in_tdata[7:0], green: in_tdata[15:8],
                   blue: in_tdata[23:16], alpha: in_tdata[31:24]};

  sba_queue u_q (.clk, .rst_n, .flush, .push(in_tvalid && !full), .push_data(pushd),
                 .full, .pop, .empty, .pop_data(popd));

  sba_engine #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .MAX_RADIUS(MAX_RADIUS))
    u_eng (.clk, .rst_n, .flush, .radius(radius_r), .width_cfg(width_r),
           .height_cfg(height_r), .cmd_valid(!empty), .cmd(popd), .cmd_pop(pop),
           .res_valid(out_tvalid), .res_ready(out_tready), .res_data(res));

  assign out_tuser = res[0];
  assign out_tdata = res[32:1];
  assign out_tlast = res[33];
endmodule
`default_nettype wire

// ===== sim/stack_blur_argb_test.sv =====
// Self-checking bench for stack_blur_argb: streams pixel loads and reads, predicts
// the blurred frame in the bench and compares every output transfer. Needs sba_pkg.
`timescale 1ns / 100ps
`default_nettype none
module stack_blur_argb_test import sba_pkg::*;;

  localparam int FRAME_MAX = 128;
  localparam int RAD_MAX   = 32;
  localparam int CELLS     = FRAME_MAX * FRAME_MAX;
  localparam int STALL_LIMIT = 400000;

  typedef struct {
    logic        ready;
    logic [31:0] pixel;
    logic        last;
  } blur_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = FUNC_LOAD;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_RADIUS;
  logic [7:0]  cfg_data = '0;

  stack_blur_argb u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // bench copy of the block state; pixels kept in tdata order
  logic [31:0] src_frame [CELLS];
  logic [31:0] row_frame [CELLS];
  int unsigned radius_reg, width_reg, height_reg;
  int unsigned load_pos, read_pos;
  bit          blurred_ready;

  blur_result_t pending_pixels[$];
  int  errors = 0;
  int  send_idle_pct = 0, recv_idle_pct = 0;
  int  quiet_cycles = 0;

  function automatic int unsigned eff_size(int unsigned v);
    if (v < 1) return 1;
    if (v > FRAME_MAX) return FRAME_MAX;
    return v;
  endfunction

  function automatic logic [31:0] blur_tap(bit from_rows, int base, int stride, int n,
                                           int pos, int r);
    logic [31:0] res;
    logic [31:0] px;
    int unsigned acc;
    int q, idx;
    res = '0;
    for (int k = 0; k < 4; k++) begin
      acc = 0;
      for (int i = -r; i <= r; i++) begin
        q = pos + i;
        if (q < 0) q = 0;
        if (q > n - 1) q = n - 1;
        idx = base + q * stride;
        px = from_rows ? row_frame[idx] : src_frame[idx];
        acc += ((px >> (8 * k)) & 32'hff) * (r + 1 - (i < 0 ? -i : i));
      end
      res |= ((acc / ((r + 1) * (r + 1))) & 32'hff) << (8 * k);
    end
    return res;
  endfunction

  function automatic void blur_frame(int w, int h);
    int r;
    r = (radius_reg > RAD_MAX) ? RAD_MAX : radius_reg;
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        row_frame[y * w + x] = blur_tap(1'b0, y * w, 1, w, x, r);
    for (int x = 0; x < w; x++)
      for (int y = 0; y < h; y++)
        src_frame[x + y * w] = blur_tap(1'b1, x, w, h, y, r);
  endfunction

  function automatic void predict_item(logic func, logic [31:0] data);
    int unsigned w, h;
    blur_result_t res;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    if (func == FUNC_LOAD) begin
      if (load_pos == 0) begin
        blurred_ready = 1'b0;
        read_pos = 0;
      end
      src_frame[load_pos] = data;
      load_pos++;
      if (load_pos >= w * h) begin
        blur_frame(w, h);
        blurred_ready = 1'b1;
        load_pos = 0;
        read_pos = 0;
      end
    end else begin
      if (!blurred_ready) begin
        res = '{1'b0, 32'h0, 1'b0};
      end else begin
        if (read_pos >= w * h) read_pos = 0;
        res.ready = 1'b1;
        res.pixel = src_frame[read_pos];
        res.last = (read_pos == w * h - 1);
        read_pos = res.last ? 0 : read_pos + 1;
      end
      pending_pixels.push_back(res);
    end
  endfunction

  // one input transfer; valid stays high between back-to-back items
  task automatic send_item(logic func, logic [31:0] data);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    predict_item(func, data);
  endtask

  task automatic load_pixel(logic [31:0] px);
    send_item(FUNC_LOAD, px);
  endtask

  task automatic read_pixels(int n);
    repeat (n) send_item(FUNC_READ, $urandom);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    drain_results();
    repeat (50) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RADIUS: radius_reg = val & 8'h3f;
      REG_WIDTH:  width_reg = val;
      REG_HEIGHT: height_reg = val;
      default: ;
    endcase
    load_pos = 0;
    read_pos = 0;
    blurred_ready = 1'b0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic setup_frame(int rad, int w, int h);
    write_reg(REG_RADIUS, 8'(rad));
    write_reg(REG_WIDTH, 8'(w));
    write_reg(REG_HEIGHT, 8'(h));
  endtask

  task automatic load_frame(int n);
    repeat (n) load_pixel($urandom);
  endtask

  // reads with nothing loaded answer not ready
  task automatic test_read_before_frame();
    read_pixels(3);
  endtask

  task automatic test_pass_through();
    setup_frame(0, 4, 3);
    load_pixel(32'h0000_0000);
    load_pixel(32'hffff_ffff);
    load_pixel(32'h00ff_00ff);
    load_pixel(32'hff00_ff00);
    load_frame(8);
    read_pixels(14);  // runs past the end and wraps
  endtask

  task automatic test_size_extremes();
    setup_frame(63, 0, 5);      // radius clamps, zero width acts as one
    load_frame(5);
    read_pixels(5);
    setup_frame(32, 255, 1);    // width clamps to the maximum
    for (int i = 0; i < FRAME_MAX; i++) load_pixel((i & 1) ? 32'hffff_ffff : 32'h0);
    read_pixels(3);
    setup_frame(33, 1, 128);
    load_frame(FRAME_MAX);
    read_pixels(2);
    setup_frame(1, 128, 0);
    load_frame(FRAME_MAX);
    read_pixels(2);
  endtask

  task automatic test_abandon_and_restart();
    setup_frame(2, 3, 3);
    load_frame(4);
    read_pixels(1);
    write_reg(REG_RADIUS, 3);   // frame dropped
    read_pixels(1);
    load_frame(9);
    read_pixels(2);
    load_frame(1);              // new frame hides the old one
    read_pixels(2);
    load_frame(8);
    read_pixels(9);
  endtask

  task automatic test_random_frames(int budget);
    int sent, w, h, rad, cells, extra;
    sent = 0;
    while (sent < budget) begin
      rad = ($urandom_range(9) == 0) ? $urandom_range(63, 33) : $urandom_range(6);
      w = ($urandom_range(19) == 0) ? $urandom_range(255, 120) : $urandom_range(8, 1);
      h = ($urandom_range(4) == 0) ? 1 : $urandom_range(8, 1);
      if (w > 8) h = $urandom_range(2, 1);
      if ($urandom_range(3) != 0 || radius_reg != rad) write_reg(REG_RADIUS, 8'(rad));
      if ($urandom_range(3) != 0 || width_reg != w) write_reg(REG_WIDTH, 8'(w));
      if ($urandom_range(3) != 0 || height_reg != h) write_reg(REG_HEIGHT, 8'(h));
      cells = eff_size(w) * eff_size(h);
      for (int i = 0; i < cells; i++) begin
        if ($urandom_range(9) == 0) begin
          send_item(FUNC_READ, $urandom);
          sent++;
        end
        load_pixel($urandom);
        sent++;
        // only break a frame before its last pixel, so no blur is running
        if (i == cells / 2 && i < cells - 1 && $urandom_range(19) == 0) begin
          write_reg(REG_WIDTH, 8'(w));   // broken frame
          i = -1;
        end
      end
      extra = $urandom_range(cells + 3);
      read_pixels(extra + 1);
      sent += extra + 1;
    end
  endtask

  // output side: random stalls, one check per transfer
  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    blur_result_t exp_px;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result tuser=%b tdata=%h tlast=%b",
                 $time, out_tuser, out_tdata, out_tlast);
        errors++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_tuser !== exp_px.ready) begin
          $display("%0t: ready_res expected %b actual %b", $time, exp_px.ready, out_tuser);
          errors++;
        end
        if (out_tdata !== exp_px.pixel) begin
          $display("%0t: pixel expected %h actual %h", $time, exp_px.pixel, out_tdata);
          errors++;
        end
        if (out_tlast !== exp_px.last) begin
          $display("%0t: last_pixel expected %b actual %b", $time, exp_px.last, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_pixels.size());
      $display("stack_blur_argb_test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      src_frame[i] = '0;
      row_frame[i] = '0;
    end
    radius_reg = 0;
    width_reg = FRAME_MAX;
    height_reg = FRAME_MAX;
    load_pos = 0;
    read_pos = 0;
    blurred_ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 36;
    recv_idle_pct = 73;
    test_read_before_frame();
    test_pass_through();
    test_size_extremes();
    test_abandon_and_restart();
    test_random_frames(300);
    send_idle_pct = 73;
    recv_idle_pct = 36;
    test_random_frames(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(300);

    drain_results();
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("stack_blur_argb_test passed");
    else
      $display("stack_blur_argb_test failed");
    $finish;
  end
endmodule
`default_nettype wire
